@@ src/mctbu_pkg.sv @@
// ---------------------------------------------------------------------------
// mctbu_pkg: shared types and constants of the boundary update block
// Holds the sequencer states, configuration register indexes, result kinds
// and the fixed-point constants used by the probability window datapath.
// ---------------------------------------------------------------------------
package mctbu_pkg;

  // Probabilities are unsigned 1.62 fixed-point values that need 63 bits.
  localparam int unsigned PROB_W = 63;
  localparam logic [PROB_W-1:0] ONE_Q62 = {1'b1, 62'd0};

  // At most this many stop records go out for one step.
  localparam int unsigned MAX_STOPS = 62;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEVEL        = 2'd0;
  localparam logic [1:0] REG_REPORT_STOPS = 2'd1;
  localparam logic [1:0] REG_START_LOWER  = 2'd2;
  localparam logic [1:0] REG_START_UPPER  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_UPPER  = 2'd0;
  localparam logic [1:0] KIND_LOWER  = 2'd1;
  localparam logic [1:0] KIND_BOUNDS = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SPREAD,
    ST_SPR_DRAIN,
    ST_UP_RD,
    ST_UP_CHK,
    ST_LO_RD,
    ST_LO_CHK,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_BND,
    ST_SHIFT,
    ST_SH_DRAIN
  } state_t;

  // One buffered stop record.
  typedef struct packed {
    logic              lower;
    logic [31:0]       pos;
    logic [PROB_W-1:0] prob;
  } stop_rec_t;

endpackage

@@ src/monte_carlo_test_boundary_update.sv @@
// ---------------------------------------------------------------------------
// monte_carlo_test_boundary_update: stopping boundary tracker
// Follows the live probability mass of a binomial walk between two stopping
// boundaries, held in one window memory, and reports the boundaries per step.
// ---------------------------------------------------------------------------
// Usage. Each transfer on the in_ channel is one step carrying its cumulative
// error budget in in_max_error. The step produces optional stop records
// (when report_stops is set) and always ends with a bounds record that has
// out_last high. Configuration registers are written over the cfg_ channel;
// cfg_ready is high only while the block is idle, and in_stall is held high
// while a write is offered. A write to start_lower or start_upper restarts
// the walk.
// The block works on one step at a time. A step spreads the window (one
// memory read-modify-write per live entry through a three-stage multiply
// pipeline), tests the upper and then the lower boundary entry by entry,
// emits the buffered stop records and the bounds record, and slides the
// window down when the lower boundary moved.
// in_stall stays high until the step is complete.
// Reset: a synchronous low rst_n loads the register defaults, and the block
// writes the unit mass into window entry zero before it goes idle.
// Results leave from an output register; while out_stall is high the record
// holds and the sequencer waits before loading the next one.
// ---------------------------------------------------------------------------
module monte_carlo_test_boundary_update #(
  parameter int unsigned WINDOW_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Step channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [62:0]                  in_max_error,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_kind,
  output logic [31:0]                  out_step_number,
  output logic signed [31:0]           out_stop_position,
  output logic [62:0]                  out_stop_probability,
  output logic signed [31:0]           out_lower_bound,
  output logic signed [31:0]           out_upper_bound,
  output logic                         out_overflow,
  output logic                         out_last,
  // Configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PW = mctbu_pkg::PROB_W;

  mctbu_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [31:0] level_r;
  logic        report_stops_r;
  logic [31:0] start_lower_r;
  logic [31:0] start_upper_r;

  // Walk state between steps.
  logic [31:0]   window_base_r;
  logic [CW-1:0] upper_offset_r;
  logic [63:0]   upper_error_r;
  logic [63:0]   lower_error_r;
  logic [31:0]   step_count_r;

  // Per-step working registers.
  logic [62:0]   maxe_r;
  logic [31:0]   sn_r;
  logic          ovf_r;
  logic [AW-1:0] cnt_r;
  logic [CW-1:0] ucnt_r;
  logic [CW-1:0] lcnt_r;
  logic [CW-1:0] mv_i_r;
  logic [5:0]    nst_r;
  logic [5:0]    ecnt_r;

  // Window memory.
  logic [PW-1:0] mem [WINDOW_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [PW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;
  logic [PW-1:0] mem_rd_r;

  // Stop record buffer.
  mctbu_pkg::stop_rec_t sbuf [64];
  logic                 sb_we;
  mctbu_pkg::stop_rec_t sb_wd;
  mctbu_pkg::stop_rec_t sb_rd_r;

  // Spread pipeline.
  logic          v1_r, z1_r, v2_r, v3_r;
  logic [AW-1:0] wa1_r, wa2_r, wa3_r;
  logic [63:0]   m_ha_r, m_la_r, m_hb_r;
  logic [64:0]   m_lb_r;
  logic [PW-1:0] pa_r, pb_r, pbprev_r;
  logic [PW-1:0] sp_data;
  logic [32:0]   coef_b;

  // Window slide write tag.
  logic          mv_v_r;
  logic [AW-1:0] mv_wa_r;

  // Output register.
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_sn_r;
  logic [31:0] out_pos_r;
  logic [62:0] out_prob_r;
  logic [31:0] out_lb_r;
  logic [31:0] out_ub_r;
  logic        out_ovf_r;
  logic        out_last_r;
  logic        out_free;
  logic        out_load;

  // Decision helpers.
  logic          in_acc;
  logic          cfg_acc;
  logic [63:0]   up_sum;
  logic [63:0]   lo_sum;
  logic          up_take;
  logic          lo_take;
  logic [CW-1:0] mv_count;
  logic signed [33:0] init_gap;
  logic [CW-1:0] init_off;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = (state_r == mctbu_pkg::ST_IDLE);
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign in_stall = (state_r != mctbu_pkg::ST_IDLE) || cfg_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == mctbu_pkg::ST_EM_LD)
                              || (state_r == mctbu_pkg::ST_EM_BND));

  assign up_sum  = {1'b0, mem_rd_r} + upper_error_r;
  assign lo_sum  = {1'b0, mem_rd_r} + lower_error_r;
  assign up_take = (up_sum <= {1'b0, maxe_r});
  assign lo_take = (lo_sum <= {1'b0, maxe_r});
  assign mv_count = ucnt_r - lcnt_r;
  assign coef_b  = 33'h1_0000_0000 - {1'b0, level_r};
  assign sp_data = z1_r ? '0 : mem_rd_r;

  // Start gap between the boundaries, clamped to the window.
  assign init_gap = $signed({{2{start_upper_r[31]}}, start_upper_r})
                  - $signed({{2{start_lower_r[31]}}, start_lower_r}) - 34'sd1;
  always_comb begin
    if (init_gap < 34'sd0) begin
      init_off = '0;
    end else if (init_gap > $signed(34'(WINDOW_DEPTH))) begin
      init_off = CW'(WINDOW_DEPTH);
    end else begin
      init_off = init_gap[CW-1:0];
    end
  end

  // Window memory ports.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wa3_r;
    mem_wd = pa_r + pbprev_r;
    mem_ra = '0;
    if (state_r == mctbu_pkg::ST_INIT) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = mctbu_pkg::ONE_Q62;
    end else if (v3_r) begin
      mem_we = 1'b1;
    end else if (mv_v_r) begin
      mem_we = 1'b1;
      mem_wa = mv_wa_r;
      mem_wd = mem_rd_r;
    end
    case (state_r)
      mctbu_pkg::ST_SPREAD: mem_ra = cnt_r - AW'(1);
      mctbu_pkg::ST_UP_RD:  mem_ra = AW'(ucnt_r - CW'(1));
      mctbu_pkg::ST_LO_RD:  mem_ra = AW'(lcnt_r);
      mctbu_pkg::ST_SHIFT:  mem_ra = AW'(lcnt_r + mv_i_r);
      default:              mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  // Stop record buffer ports.
  always_comb begin
    sb_we       = 1'b0;
    sb_wd.lower = (state_r == mctbu_pkg::ST_LO_CHK);
    sb_wd.prob  = mem_rd_r;
    if (state_r == mctbu_pkg::ST_LO_CHK) begin
      sb_wd.pos = window_base_r + 32'(lcnt_r);
    end else begin
      sb_wd.pos = window_base_r + 32'(ucnt_r) - 32'd1;
    end
    if (report_stops_r && (nst_r < 6'(mctbu_pkg::MAX_STOPS))) begin
      sb_we = ((state_r == mctbu_pkg::ST_UP_CHK) && up_take)
           || ((state_r == mctbu_pkg::ST_LO_CHK) && lo_take);
    end
  end

  always_ff @(posedge clk) begin
    if (sb_we) begin
      sbuf[nst_r] <= sb_wd;
    end
    sb_rd_r <= sbuf[ecnt_r];
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mctbu_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mctbu_pkg::ST_INIT:   state_nxt = mctbu_pkg::ST_IDLE;
      mctbu_pkg::ST_IDLE: begin
        if (cfg_acc && (cfg_index inside {mctbu_pkg::REG_START_LOWER,
                                          mctbu_pkg::REG_START_UPPER})) begin
          state_nxt = mctbu_pkg::ST_INIT;
        end else if (in_acc) begin
          state_nxt = mctbu_pkg::ST_SPREAD;
        end
      end
      mctbu_pkg::ST_SPREAD: begin
        if (cnt_r == '0) begin
          state_nxt = mctbu_pkg::ST_SPR_DRAIN;
        end
      end
      mctbu_pkg::ST_SPR_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          state_nxt = mctbu_pkg::ST_UP_RD;
        end
      end
      mctbu_pkg::ST_UP_RD: begin
        state_nxt = (ucnt_r == '0) ? mctbu_pkg::ST_LO_RD : mctbu_pkg::ST_UP_CHK;
      end
      mctbu_pkg::ST_UP_CHK: begin
        state_nxt = up_take ? mctbu_pkg::ST_UP_RD : mctbu_pkg::ST_LO_RD;
      end
      mctbu_pkg::ST_LO_RD: begin
        state_nxt = (lcnt_r < ucnt_r) ? mctbu_pkg::ST_LO_CHK : mctbu_pkg::ST_EM_RD;
      end
      mctbu_pkg::ST_LO_CHK: begin
        state_nxt = lo_take ? mctbu_pkg::ST_LO_RD : mctbu_pkg::ST_EM_RD;
      end
      mctbu_pkg::ST_EM_RD: begin
        state_nxt = (ecnt_r == nst_r) ? mctbu_pkg::ST_EM_BND : mctbu_pkg::ST_EM_LD;
      end
      mctbu_pkg::ST_EM_LD: begin
        if (out_free) begin
          state_nxt = mctbu_pkg::ST_EM_RD;
        end
      end
      mctbu_pkg::ST_EM_BND: begin
        if (out_free) begin
          state_nxt = (lcnt_r == '0) ? mctbu_pkg::ST_IDLE : mctbu_pkg::ST_SHIFT;
        end
      end
      mctbu_pkg::ST_SHIFT: begin
        if (mv_i_r == mv_count) begin
          state_nxt = mctbu_pkg::ST_SH_DRAIN;
        end
      end
      mctbu_pkg::ST_SH_DRAIN: begin
        if (!mv_v_r) begin
          state_nxt = mctbu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mctbu_pkg::ST_INIT;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r        <= 32'd214748365;
      report_stops_r <= 1'b0;
      start_lower_r  <= 32'hFFFF_FFFF;
      start_upper_r  <= 32'd1;
    end else if (cfg_acc) begin
      case (cfg_index)
        mctbu_pkg::REG_LEVEL:        level_r        <= cfg_data;
        mctbu_pkg::REG_REPORT_STOPS: report_stops_r <= cfg_data[0];
        mctbu_pkg::REG_START_LOWER:  start_lower_r  <= cfg_data;
        mctbu_pkg::REG_START_UPPER:  start_upper_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Spread pipeline: read, multiply, scale, then write back one entry above.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= (state_r == mctbu_pkg::ST_SPREAD);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    z1_r   <= (cnt_r == '0);
    wa1_r  <= cnt_r;
    wa2_r  <= wa1_r;
    wa3_r  <= wa2_r;
    m_ha_r <= 64'({33'd0, sp_data[62:32]} * {32'd0, level_r});
    m_la_r <= 64'({32'd0, sp_data[31:0]} * {32'd0, level_r});
    m_hb_r <= 64'({33'd0, sp_data[62:32]} * {31'd0, coef_b});
    m_lb_r <= 65'({33'd0, sp_data[31:0]} * {32'd0, coef_b});
    pa_r   <= PW'(m_ha_r + {32'd0, m_la_r[63:32]});
    pb_r   <= PW'(m_hb_r + {31'd0, m_lb_r[64:32]});
    if (state_r == mctbu_pkg::ST_IDLE) begin
      pbprev_r <= '0;
    end else if (v3_r) begin
      pbprev_r <= pb_r;
    end
  end

  // Window slide tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_v_r <= 1'b0;
    end else begin
      mv_v_r <= (state_r == mctbu_pkg::ST_SHIFT) && (mv_i_r != mv_count);
    end
    mv_wa_r <= AW'(mv_i_r);
  end

  // Step control and walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r  <= '0;
      upper_offset_r <= '0;
      upper_error_r  <= '0;
      lower_error_r  <= '0;
      step_count_r   <= '0;
      nst_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        mctbu_pkg::ST_INIT: begin
          window_base_r  <= start_lower_r + 32'd1;
          upper_offset_r <= init_off;
          upper_error_r  <= '0;
          lower_error_r  <= '0;
          step_count_r   <= '0;
        end
        mctbu_pkg::ST_IDLE: begin
          if (in_acc) begin
            maxe_r       <= in_max_error;
            sn_r         <= step_count_r;
            step_count_r <= step_count_r + 32'd1;
            nst_r        <= '0;
            ecnt_r       <= '0;
            lcnt_r       <= '0;
            mv_i_r       <= '0;
            if (upper_offset_r > CW'(WINDOW_DEPTH - 1)) begin
              ovf_r  <= 1'b1;
              cnt_r  <= AW'(WINDOW_DEPTH - 1);
              ucnt_r <= CW'(WINDOW_DEPTH);
            end else begin
              ovf_r  <= 1'b0;
              cnt_r  <= AW'(upper_offset_r);
              ucnt_r <= upper_offset_r + CW'(1);
            end
          end
        end
        mctbu_pkg::ST_SPREAD: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - AW'(1);
          end
        end
        mctbu_pkg::ST_UP_CHK: begin
          if (up_take) begin
            upper_error_r <= up_sum;
            ucnt_r        <= ucnt_r - CW'(1);
            if (report_stops_r) begin
              if (nst_r < 6'(mctbu_pkg::MAX_STOPS)) begin
                nst_r <= nst_r + 6'd1;
              end else begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        mctbu_pkg::ST_LO_CHK: begin
          if (lo_take) begin
            lower_error_r <= lo_sum;
            lcnt_r        <= lcnt_r + CW'(1);
            if (report_stops_r) begin
              if (nst_r < 6'(mctbu_pkg::MAX_STOPS)) begin
                nst_r <= nst_r + 6'd1;
              end else begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        mctbu_pkg::ST_EM_LD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= sb_rd_r.lower ? mctbu_pkg::KIND_LOWER : mctbu_pkg::KIND_UPPER;
            out_sn_r    <= sn_r;
            out_pos_r   <= sb_rd_r.pos;
            out_prob_r  <= sb_rd_r.prob;
            out_lb_r    <= '0;
            out_ub_r    <= '0;
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b0;
            ecnt_r      <= ecnt_r + 6'd1;
          end
        end
        mctbu_pkg::ST_EM_BND: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= mctbu_pkg::KIND_BOUNDS;
            out_sn_r    <= sn_r;
            out_pos_r   <= '0;
            out_prob_r  <= '0;
            out_lb_r    <= window_base_r + 32'(lcnt_r) - 32'd1;
            out_ub_r    <= window_base_r + 32'(ucnt_r);
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b1;
            // Slide the window so that the lowest live entry becomes entry zero.
            window_base_r  <= window_base_r + 32'(lcnt_r);
            upper_offset_r <= mv_count;
          end
        end
        mctbu_pkg::ST_SHIFT: begin
          if (mv_i_r != mv_count) begin
            mv_i_r <= mv_i_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_step_number      = out_sn_r;
  assign out_stop_position    = out_pos_r;
  assign out_stop_probability = out_prob_r;
  assign out_lower_bound      = out_lb_r;
  assign out_upper_bound      = out_ub_r;
  assign out_overflow         = out_ovf_r;
  assign out_last             = out_last_r;

  // The stop record count never passes the buffer limit.
  a_nst_limit: assert property (@(posedge clk) disable iff (!rst_n)
    nst_r <= 6'(mctbu_pkg::MAX_STOPS))
    else $error("stop record count beyond limit");

  // The lower pull never crosses the upper one.
  a_pull_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mctbu_pkg::ST_LO_RD || state_r == mctbu_pkg::ST_LO_CHK)
      |-> (lcnt_r <= ucnt_r))
    else $error("lower pull passed upper pull");

  // No window write lands while a boundary test reads the memory.
  a_no_write_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mctbu_pkg::ST_UP_CHK || state_r == mctbu_pkg::ST_LO_CHK) |-> !mem_we)
    else $error("window write during boundary test");

  // A loaded bounds record is marked last.
  a_bounds_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mctbu_pkg::ST_EM_BND && out_free) |=> (out_valid_r && out_last_r))
    else $error("bounds record without last");

endmodule
